/* src/yrr_pkg.sv */
// ----------------------------------------------------------------------------
// yrr_pkg: shared types, constants and functions
// Steer tables, fixed-point constants, queue item types, divider step.
// ----------------------------------------------------------------------------
package yrr_pkg;

  // register indexes on the APB port
  localparam logic [2:0] REG_MAX_YAW  = 3'd0;
  localparam logic [2:0] REG_FRICTION = 3'd1;
  localparam logic [2:0] REG_KU       = 3'd2;
  localparam logic [2:0] REG_AXLE     = 3'd3;
  localparam logic [2:0] REG_MIN_SPD  = 3'd4;

  // mid queue between steer front and yaw back
  localparam int MID_AW    = 4;
  localparam int MID_DEPTH = 1 << MID_AW;
  // result buffer in the back
  localparam int OUT_AW    = 5;
  localparam int OUT_DEPTH = 1 << OUT_AW;

  localparam int QW = 20;                 // quotient bits per divide
  localparam int DW = 58;                 // divisor / remainder width
  localparam int BACK_LAT = 5 + QW;       // back pipeline stages

  localparam logic signed [38:0] DEG_PER_RAD_Q16  = 39'sd3754936;
  localparam logic signed [38:0] AXIS_OFFSET      = 39'sd24159191040;  // 90 << 28
  localparam logic signed [38:0] AXIS_SPAN        = 39'sd48318382080;  // 180 << 28
  localparam logic [22:0]        SEG_WIDTH_SH13   = 23'd589824;        // (18 << 28) >> 13
  localparam logic signed [60:0] RAD_PER_DEG4_Q40 = 61'sd30704157;
  localparam logic signed [61:0] YAW_SCALE        = 62'sd32768000;
  localparam logic [45:0]        G_SCALED         = 46'd15696;
  localparam logic signed [58:0] KU_SCALE         = 59'sd1000;
  localparam logic [22:0]        CAP_DEN_SCALE    = 23'd100;

  typedef struct packed {
    logic [15:0]        max_yaw_tuning;
    logic [15:0]        tire_friction;
    logic signed [15:0] understeer_gradient;
    logic [11:0]        axle_distance_mm;
    logic [7:0]         min_speed;
  } cfg_t;

  typedef struct packed {
    logic signed [11:0] left_steer;
    logic signed [11:0] right_steer;
    logic signed [20:0] dsum;       // delta, 2^-21 rad
    logic [15:0]        speed;
  } mid_item_t;

  typedef struct packed {
    logic              empty;
    logic [MID_AW:0]   count;
  } mq_status_t;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [DW-1:0] dvs;
    logic [QW-1:0] rest;   // numerator bits still to bring down
    logic [QW-1:0] quo;
    logic          ovf;    // quotient does not fit in QW bits
  } div_lane_t;

  typedef struct packed {
    logic signed [11:0] left_steer;
    logic signed [11:0] right_steer;
    logic               low;
    logic               neg;
    logic               nzero;
  } yaw_side_t;

  // floor(x / 9) for x < 2^20
  function automatic logic [19:0] div9(input logic [19:0] x);
    logic [39:0] p;
    p = 40'(x) * 40'd932068;
    return 20'(p >> 23);
  endfunction

  // front left steer table, 1e-4 deg
  function automatic logic signed [18:0] tab_left(input logic [3:0] idx);
    logic signed [18:0] v;
    unique case (idx)
      4'd0:    v = -19'sd182240;
      4'd1:    v = -19'sd145580;
      4'd2:    v = -19'sd109180;
      4'd3:    v = -19'sd72890;
      4'd4:    v = -19'sd36540;
      4'd5:    v = 19'sd0;
      4'd6:    v = 19'sd36890;
      4'd7:    v = 19'sd74280;
      4'd8:    v = 19'sd112340;
      4'd9:    v = 19'sd151260;
      4'd10:   v = 19'sd191270;
      default: v = 19'sd0;
    endcase
    return v;
  endfunction

  // front right steer table, 1e-4 deg
  function automatic logic signed [18:0] tab_right(input logic [3:0] idx);
    logic signed [18:0] v;
    unique case (idx)
      4'd0:    v = -19'sd191260;
      4'd1:    v = -19'sd151260;
      4'd2:    v = -19'sd112340;
      4'd3:    v = -19'sd74280;
      4'd4:    v = -19'sd36890;
      4'd5:    v = 19'sd0;
      4'd6:    v = 19'sd36540;
      4'd7:    v = 19'sd72890;
      4'd8:    v = 19'sd109180;
      4'd9:    v = 19'sd145580;
      4'd10:   v = 19'sd182250;
      default: v = 19'sd0;
    endcase
    return v;
  endfunction

  // one restoring divide step: bring down a bit, subtract if it fits
  function automatic div_lane_t div_step(input div_lane_t l);
    div_lane_t  o;
    logic [DW:0] r2;
    o = l;
    r2 = {l.rem, l.rest[QW-1]};
    o.rest = {l.rest[QW-2:0], 1'b0};
    if (r2 >= {1'b0, l.dvs}) begin
      o.rem = DW'(r2 - {1'b0, l.dvs});
      o.quo = {l.quo[QW-2:0], 1'b1};
    end else begin
      o.rem = DW'(r2);
      o.quo = {l.quo[QW-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

/* src/yaw_rate_reference_unit.sv */
// ----------------------------------------------------------------------------
// yaw_rate_reference_unit: bicycle-model yaw rate reference
// Steer table interpolation and saturated yaw rate target per sample.
// ----------------------------------------------------------------------------
// One beat in (wheel angle, speed) gives one beat out (left and right front
// steer angle, yaw rate target), in order. A new beat is taken every clock
// while results keep being popped: throughput is one beat per cycle. From
// push to the result showing at the output, a beat passes the steer front,
// the mid queue and then the yaw back (5 setup stages, a 20-stage radix-2
// divider with one quotient bit per stage, and the result buffer write).
// Full rises only on credit: the front holds back once the beats in its 7
// stages plus those in the mid queue reach the queue's 16 entries, and the
// back stops draining the mid queue once the beats in its stages plus those
// in the result buffer reach the buffer's 32 entries. Registers on the APB
// port should be written only while nothing is in flight.
// ----------------------------------------------------------------------------
module yaw_rate_reference_unit (
  input  logic               clk,
  input  logic               rst,
  // APB config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input beats
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] wheel_angle,
  input  logic [15:0]        speed,
  // result beats
  output logic               empty,
  input  logic               pop,
  output logic signed [11:0] left_steer,
  output logic signed [11:0] right_steer,
  output logic signed [18:0] yaw_target
);

  yrr_pkg::cfg_t        cfg;
  logic                 wr;
  logic [2:0]           idx;

  logic                 mid_push;
  logic                 mid_pop;
  yrr_pkg::mid_item_t   mid_wdata;
  yrr_pkg::mid_item_t   mid_rdata;
  yrr_pkg::mq_status_t  mq;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  // register file; unknown addresses are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_yaw_tuning      <= 16'd256;
      cfg.tire_friction       <= 16'd512;
      cfg.understeer_gradient <= 16'sd0;
      cfg.axle_distance_mm    <= 12'd1528;
      cfg.min_speed           <= 8'd2;
    end else if (wr) begin
      unique case (idx)
        yrr_pkg::REG_MAX_YAW:  cfg.max_yaw_tuning      <= pwdata[15:0];
        yrr_pkg::REG_FRICTION: cfg.tire_friction       <= pwdata[15:0];
        yrr_pkg::REG_KU:       cfg.understeer_gradient <= signed'(pwdata[15:0]);
        yrr_pkg::REG_AXLE:     cfg.axle_distance_mm    <= pwdata[11:0];
        yrr_pkg::REG_MIN_SPD:  cfg.min_speed           <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      yrr_pkg::REG_MAX_YAW:  prdata = 32'(cfg.max_yaw_tuning);
      yrr_pkg::REG_FRICTION: prdata = 32'(cfg.tire_friction);
      yrr_pkg::REG_KU:       prdata = 32'(unsigned'(cfg.understeer_gradient));
      yrr_pkg::REG_AXLE:     prdata = 32'(cfg.axle_distance_mm);
      yrr_pkg::REG_MIN_SPD:  prdata = 32'(cfg.min_speed);
      default:               prdata = '0;
    endcase
  end

  // steer front: position, segment, interpolation
  yrr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .wheel_angle (wheel_angle),
    .speed       (speed),
    .mid_count   (mq.count),
    .mid_push    (mid_push),
    .mid_data    (mid_wdata)
  );

  // decouples the two halves
  yrr_mid_q u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mid_push),
    .wr_data (mid_wdata),
    .rd_en   (mid_pop),
    .rd_data (mid_rdata),
    .status  (mq)
  );

  // yaw back: divide, cap, saturate, buffer
  yrr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .mq          (mq),
    .mid_data    (mid_rdata),
    .mid_pop     (mid_pop),
    .empty       (empty),
    .pop         (pop),
    .left_steer  (left_steer),
    .right_steer (right_steer),
    .yaw_target  (yaw_target)
  );

endmodule

/* src/yrr_mid_q.sv */
// ----------------------------------------------------------------------------
// yrr_mid_q: queue between steer front and yaw back
// Flip-flop FIFO of steer results waiting for the divider pipeline.
// ----------------------------------------------------------------------------
module yrr_mid_q (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  yrr_pkg::mid_item_t    wr_data,
  input  logic                  rd_en,
  output yrr_pkg::mid_item_t    rd_data,
  output yrr_pkg::mq_status_t   status
);

  yrr_pkg::mid_item_t          mem [yrr_pkg::MID_DEPTH];
  logic [yrr_pkg::MID_AW-1:0]  wr_ptr;
  logic [yrr_pkg::MID_AW-1:0]  rd_ptr;
  logic [yrr_pkg::MID_AW:0]    count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (yrr_pkg::MID_AW+1)'(wr_en) - (yrr_pkg::MID_AW+1)'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  assign rd_data      = mem[rd_ptr];
  assign status.empty = (count == '0);
  assign status.count = count;

endmodule

/* src/yrr_front.sv */
// ----------------------------------------------------------------------------
// yrr_front: steer angle front end
// Wheel angle to table position, segment and fraction, interpolation of both
// steer tables, rounding. Seven stages; entry is gated by queue credit.
// ----------------------------------------------------------------------------
module yrr_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic signed [15:0]          wheel_angle,
  input  logic [15:0]                 speed,
  input  logic [yrr_pkg::MID_AW:0]    mid_count,
  output logic                        mid_push,
  output yrr_pkg::mid_item_t          mid_data
);

  localparam int NST = 7;

  logic [NST-1:0] vld;
  logic [2:0]     fcnt;
  logic           acc;
  logic [15:0]    spd [NST];

  logic signed [38:0] s1_pos;
  logic               s1_lo;
  logic               s1_hi;
  logic [3:0]         s2_seg;
  logic [22:0]        s2_posh;
  logic               s2_clamp;
  logic [19:0]        s3_x;
  logic [19:0]        s3_q;
  logic [15:0]        s3_frac;
  logic signed [18:0] s3_al, s3_bl, s3_ar, s3_br;
  logic signed [35:0] s4_vl, s4_vr;
  logic signed [60:0] s5_pl, s5_pr;
  logic signed [19:0] s6_l20, s6_r20;

  function automatic logic signed [19:0] rnd40(input logic signed [60:0] v);
    logic [60:0] m;
    logic [20:0] r;
    m = v[60] ? 61'(-v) : 61'(v);
    r = 21'((m + (61'd1 << 39)) >> 40);
    return v[60] ? -20'(signed'(r)) : 20'(signed'(r));
  endfunction

  function automatic logic signed [11:0] steer12(input logic signed [19:0] v);
    logic [19:0] m;
    logic [11:0] r;
    logic signed [11:0] o;
    m = v[19] ? 20'(-v) : 20'(v);
    r = 12'((m + 20'd128) >> 8);
    if (v[19]) o = (r > 12'd2047) ? -12'sd2048 : -signed'(r);
    else       o = r[11] ? 12'sd2047 : signed'(r);
    return o;
  endfunction

  assign full = (6'(fcnt) + 6'(mid_count)) >= 6'(yrr_pkg::MID_DEPTH);
  assign acc  = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      fcnt <= '0;
    end else begin
      vld  <= {vld[NST-2:0], acc};
      fcnt <= fcnt + 3'(acc) - 3'(vld[NST-1]);
    end
  end

  always_ff @(posedge clk) begin
    spd[0] <= speed;
    for (int i = 1; i < NST; i++) spd[i] <= spd[i-1];
  end

  // stage 1: position on the table axis, 2^-28 deg
  always_ff @(posedge clk) begin
    s1_pos <= 39'(wheel_angle) * yrr_pkg::DEG_PER_RAD_Q16 + yrr_pkg::AXIS_OFFSET;
  end

  // stage 2: clamp and segment
  assign s1_lo = (s1_pos <= 39'sd0);
  assign s1_hi = (s1_pos >= yrr_pkg::AXIS_SPAN);

  always_ff @(posedge clk) begin
    s2_clamp <= s1_lo || s1_hi;
    s2_posh  <= s1_pos[35:13];
    if (s1_lo)      s2_seg <= 4'd0;
    else if (s1_hi) s2_seg <= 4'd10;
    else            s2_seg <= 4'(yrr_pkg::div9(20'(s1_pos[35:29])));
  end

  // stage 3: fraction and table entries
  assign s3_x = 20'(s2_posh - 23'(s2_seg) * yrr_pkg::SEG_WIDTH_SH13);
  assign s3_q = yrr_pkg::div9(s3_x);

  always_ff @(posedge clk) begin
    s3_frac <= s2_clamp ? 16'd0 : s3_q[15:0];
    s3_al   <= yrr_pkg::tab_left(s2_seg);
    s3_ar   <= yrr_pkg::tab_right(s2_seg);
    s3_bl   <= (s2_seg == 4'd10) ? yrr_pkg::tab_left(s2_seg)
                                 : yrr_pkg::tab_left(s2_seg + 4'd1);
    s3_br   <= (s2_seg == 4'd10) ? yrr_pkg::tab_right(s2_seg)
                                 : yrr_pkg::tab_right(s2_seg + 4'd1);
  end

  // stage 4: interpolate, 1e-4 deg Q16
  always_ff @(posedge clk) begin
    s4_vl <= (36'(s3_al) <<< 16)
           + 36'(s3_bl - s3_al) * 36'(signed'({1'b0, s3_frac}));
    s4_vr <= (36'(s3_ar) <<< 16)
           + 36'(s3_br - s3_ar) * 36'(signed'({1'b0, s3_frac}));
  end

  // stage 5: to radians
  always_ff @(posedge clk) begin
    s5_pl <= 61'(s4_vl) * yrr_pkg::RAD_PER_DEG4_Q40;
    s5_pr <= 61'(s4_vr) * yrr_pkg::RAD_PER_DEG4_Q40;
  end

  // stage 6: round to 2^-20 rad
  always_ff @(posedge clk) begin
    s6_l20 <= rnd40(s5_pl);
    s6_r20 <= rnd40(s5_pr);
  end

  // stage 7: steer outputs and delta sum
  always_ff @(posedge clk) begin
    mid_data.left_steer  <= steer12(s6_l20);
    mid_data.right_steer <= steer12(s6_r20);
    mid_data.dsum        <= 21'(s6_l20) + 21'(s6_r20);
    mid_data.speed       <= spd[NST-2];
  end

  assign mid_push = vld[NST-1];

endmodule

/* src/yrr_back.sv */
// ----------------------------------------------------------------------------
// yrr_back: yaw rate back end
// Numerator, denominator and cap terms, two radix-2 divide lanes, final
// select and saturation, result buffer. Entry is gated by buffer credit.
// ----------------------------------------------------------------------------
module yrr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  yrr_pkg::cfg_t               cfg,
  input  yrr_pkg::mq_status_t         mq,
  input  yrr_pkg::mid_item_t          mid_data,
  output logic                        mid_pop,
  output logic                        empty,
  input  logic                        pop,
  output logic signed [11:0]          left_steer,
  output logic signed [11:0]          right_steer,
  output logic signed [18:0]          yaw_target
);

  localparam int BL = yrr_pkg::BACK_LAT;
  localparam int QW = yrr_pkg::QW;
  localparam int DW = yrr_pkg::DW;

  typedef struct packed {
    logic signed [11:0] left_steer;
    logic signed [11:0] right_steer;
    logic signed [18:0] yaw;
  } res_t;

  logic [BL-1:0]             vld;
  logic [4:0]                bcnt;
  logic [yrr_pkg::OUT_AW:0]  ocnt;
  logic                      take;
  logic                      done;
  logic                      opop;

  // stage 1
  logic [31:0]        b1_ss;
  logic signed [36:0] b1_sd;
  logic [31:0]        b1_sm;
  logic [22:0]        b1_dc;
  yrr_pkg::yaw_side_t b1_side;
  // stage 2
  logic signed [48:0] b2_kss;
  logic signed [61:0] b2_num;
  logic [45:0]        b2_nc;
  logic [22:0]        b2_dc;
  yrr_pkg::yaw_side_t b2_side;
  // stage 3
  logic signed [58:0] b3_den;
  logic signed [61:0] b3_num;
  logic [45:0]        b3_nc;
  logic [22:0]        b3_dc;
  yrr_pkg::yaw_side_t b3_side;
  // stage 4
  logic [60:0]        b4_un;
  logic [DW-1:0]      b4_ud;
  logic [45:0]        b4_nc;
  logic [22:0]        b4_dc;
  yrr_pkg::yaw_side_t b4_side;
  // divide lanes
  yrr_pkg::div_lane_t ylane [QW+1];
  yrr_pkg::div_lane_t clane [QW+1];
  yrr_pkg::yaw_side_t side  [QW+1];

  logic [QW-1:0]      yq, cq, mq_min;
  res_t               res;
  res_t               buf_mem [yrr_pkg::OUT_DEPTH];
  logic [yrr_pkg::OUT_AW-1:0] wr_ptr, rd_ptr;

  assign take    = !mq.empty && ((7'(bcnt) + 7'(ocnt)) < 7'(yrr_pkg::OUT_DEPTH));
  assign mid_pop = take;
  assign done    = vld[BL-1];
  assign opop    = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      bcnt <= '0;
    end else begin
      vld  <= {vld[BL-2:0], take};
      bcnt <= bcnt + 5'(take) - 5'(done);
    end
  end

  // stage 1: products of the inputs
  always_ff @(posedge clk) begin
    b1_ss <= 32'(mid_data.speed) * 32'(mid_data.speed);
    b1_sd <= 37'(signed'({1'b0, mid_data.speed})) * 37'(mid_data.dsum);
    b1_sm <= 32'(cfg.max_yaw_tuning) * 32'(cfg.tire_friction);
    b1_dc <= 23'(mid_data.speed) * yrr_pkg::CAP_DEN_SCALE;
    b1_side.left_steer  <= mid_data.left_steer;
    b1_side.right_steer <= mid_data.right_steer;
    b1_side.low         <= (mid_data.speed <= 16'(cfg.min_speed));
    b1_side.neg         <= 1'b0;
    b1_side.nzero       <= 1'b0;
  end

  // stage 2: ku * v^2, numerator, cap numerator
  always_ff @(posedge clk) begin
    b2_kss  <= 49'(cfg.understeer_gradient) * 49'(signed'({1'b0, b1_ss}));
    b2_num  <= 62'(b1_sd) * yrr_pkg::YAW_SCALE;
    b2_nc   <= 46'(b1_sm) * yrr_pkg::G_SCALED;
    b2_dc   <= b1_dc;
    b2_side <= b1_side;
  end

  // stage 3: denominator, 2^-32 mm
  always_ff @(posedge clk) begin
    b3_den  <= signed'(59'(cfg.axle_distance_mm) << 32) + 59'(b2_kss) * yrr_pkg::KU_SCALE;
    b3_num  <= b2_num;
    b3_nc   <= b2_nc;
    b3_dc   <= b2_dc;
    b3_side <= b2_side;
  end

  // stage 4: magnitudes and quotient sign
  always_ff @(posedge clk) begin
    b4_un   <= b3_num[61] ? 61'(-b3_num) : 61'(b3_num);
    b4_ud   <= b3_den[58] ? DW'(-b3_den) : DW'(b3_den);
    b4_nc   <= b3_nc;
    b4_dc   <= b3_dc;
    b4_side.left_steer  <= b3_side.left_steer;
    b4_side.right_steer <= b3_side.right_steer;
    b4_side.low         <= b3_side.low;
    b4_side.neg         <= b3_num[61] != b3_den[58];
    b4_side.nzero       <= (b3_num == '0);
  end

  // stage 5: overflow check and first partial remainder
  always_ff @(posedge clk) begin
    ylane[0].ovf  <= (b4_un >> QW) >= 61'(b4_ud);
    ylane[0].rem  <= DW'(b4_un >> QW);
    ylane[0].rest <= b4_un[QW-1:0];
    ylane[0].dvs  <= b4_ud;
    ylane[0].quo  <= '0;
    clane[0].ovf  <= (b4_nc >> QW) >= 46'(b4_dc);
    clane[0].rem  <= DW'(b4_nc >> QW);
    clane[0].rest <= b4_nc[QW-1:0];
    clane[0].dvs  <= DW'(b4_dc);
    clane[0].quo  <= '0;
    side[0]       <= b4_side;
  end

  // one quotient bit per stage in each lane
  for (genvar k = 0; k < QW; k++) begin : g_div
    always_ff @(posedge clk) begin
      ylane[k+1] <= yrr_pkg::div_step(ylane[k]);
      clane[k+1] <= yrr_pkg::div_step(clane[k]);
      side[k+1]  <= side[k];
    end
  end

  // final select: cap positive results from above, saturate to the 19-bit signed range
  assign yq     = ylane[QW].ovf ? '1 : ylane[QW].quo;
  assign cq     = clane[QW].ovf ? '1 : clane[QW].quo;
  assign mq_min = (yq < cq) ? yq : cq;

  always_comb begin
    res.left_steer  = side[QW].left_steer;
    res.right_steer = side[QW].right_steer;
    if (side[QW].low || side[QW].nzero) begin
      res.yaw = '0;
    end else if (side[QW].neg) begin
      res.yaw = (|yq[QW-1:18]) ? -19'sd262144 : -signed'(19'(yq));
    end else begin
      res.yaw = (|mq_min[QW-1:18]) ? 19'sd262143 : signed'(19'(mq_min));
    end
  end

  // result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      ocnt   <= '0;
    end else begin
      if (done) wr_ptr <= wr_ptr + 1'b1;
      if (opop) rd_ptr <= rd_ptr + 1'b1;
      ocnt <= ocnt + (yrr_pkg::OUT_AW+1)'(done) - (yrr_pkg::OUT_AW+1)'(opop);
    end
  end

  always_ff @(posedge clk) begin
    if (done) buf_mem[wr_ptr] <= res;
  end

  assign empty       = (ocnt == '0);
  assign left_steer  = buf_mem[rd_ptr].left_steer;
  assign right_steer = buf_mem[rd_ptr].right_steer;
  assign yaw_target  = buf_mem[rd_ptr].yaw;

endmodule
